// File: design/hdr_color_scale_and_gamma_core_assert.svh
// assertion macros shared by the pixel pipeline modules
// both expect i_clk and i_rst_n in the scope where they are used
`ifndef HDR_COLOR_SCALE_AND_GAMMA_CORE_ASSERT_SVH
`define HDR_COLOR_SCALE_AND_GAMMA_CORE_ASSERT_SVH

// same-cycle implication
`define HCSG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/hcsg_pkg.sv
package hcsg_pkg;

    // fixed output format
    localparam int OUT_W   = 16;
    localparam int NUM_CH  = 3;
    localparam int ONE_Q16 = 65536;
    localparam int MAX_V   = 65535;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // parameter defaults
    localparam int DEF_INT_BITS         = 8;
    localparam int DEF_GAMMA_TABLE_BITS = 10;

    // pipeline stage map
    localparam int DIV_STEPS = OUT_W;
    localparam int ST_IN     = 0;
    localparam int ST_MUL    = 1;
    localparam int ST_DIV0   = 2;
    localparam int ST_SEL    = ST_DIV0 + DIV_STEPS;
    localparam int ST_OUT    = ST_SEL + 1;
    localparam int N_STAGES  = ST_OUT + 1;

endpackage

// File: design/hcsg_pix_in_if.sv
interface hcsg_pix_in_if #(
    parameter int INT_BITS = 8
);
    localparam int IN_W = 16 + INT_BITS;

    logic            valid;
    logic            ready;
    logic [IN_W-1:0] red_in;
    logic [IN_W-1:0] green_in;
    logic [IN_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// File: design/hcsg_pix_out_if.sv
interface hcsg_pix_out_if;
    import hcsg_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

// File: design/hcsg_max.sv
module hcsg_max #(
    parameter int INT_BITS = hcsg_pkg::DEF_INT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [INT_BITS+15:0] i_red,
    input  logic [INT_BITS+15:0] i_green,
    input  logic [INT_BITS+15:0] i_blue,
    output logic [INT_BITS+15:0] o_chan [hcsg_pkg::NUM_CH],
    output logic [INT_BITS+15:0] o_max,
    output logic                 o_scale
);
    import hcsg_pkg::*;

    localparam int IN_W = 16 + INT_BITS;
    localparam logic [IN_W-1:0] ONE_W = IN_W'(ONE_Q16);

    logic [IN_W-1:0] w_max_rg;
    logic [IN_W-1:0] w_max;

    // largest channel across all three lanes
    assign w_max_rg = (i_red > i_green) ? i_red : i_green;
    assign w_max    = (w_max_rg > i_blue) ? w_max_rg : i_blue;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_chan[CH_RED]   <= i_red;
            o_chan[CH_GREEN] <= i_green;
            o_chan[CH_BLUE]  <= i_blue;
            o_max            <= w_max;
            o_scale          <= (w_max > ONE_W);
        end
    end

endmodule

// File: design/hcsg_gamma.sv
module hcsg_gamma #(
    parameter int GAMMA_TABLE_BITS = hcsg_pkg::DEF_GAMMA_TABLE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_en_rd,
    input  logic                       i_en_out,
    input  logic [hcsg_pkg::OUT_W-1:0] i_v,
    output logic [hcsg_pkg::OUT_W-1:0] o_y
);
    import hcsg_pkg::*;

    localparam int ROM_N  = 2 ** GAMMA_TABLE_BITS;
    localparam int ADDR_W = GAMMA_TABLE_BITS + 1;
    localparam int F_W    = OUT_W - GAMMA_TABLE_BITS;
    localparam int P_W    = OUT_W + F_W;
    localparam logic [P_W-1:0] HALF = P_W'(1) << (F_W - 1);

    // table step and curve exponent, as real constants
    localparam real ROM_STEP  = 1.0 / real'(ROM_N);
    localparam real GAMMA_EXP = 5.0 / 11.0;

    typedef logic [OUT_W-1:0] t_rom [0:ROM_N];

    // round-half-up of full scale times (k/N)^(5/11), evaluated at elaboration
    function automatic t_rom f_build_rom();
        t_rom rom;
        real  x;
        real  y;
        for (int k = 0; k <= ROM_N; k++) begin
            x = real'(k) * ROM_STEP;
            y = $floor(real'(MAX_V) * $pow(x, GAMMA_EXP) + 0.5);
            rom[k] = OUT_W'($rtoi(y));
        end
        return rom;
    endfunction

    localparam t_rom GAMMA_ROM = f_build_rom();

    logic [ADDR_W-1:0] w_addr_lo;
    logic [ADDR_W-1:0] w_addr_hi;
    logic [OUT_W-1:0]  r_a;
    logic [OUT_W-1:0]  r_b;
    logic [F_W-1:0]    r_f;
    logic [OUT_W-1:0]  w_d;
    logic [P_W-1:0]    w_prod;

    assign w_addr_lo = {1'b0, i_v[OUT_W-1:F_W]};
    assign w_addr_hi = w_addr_lo + ADDR_W'(1);

    // registered rom read of both neighbors
    always_ff @(posedge i_clk) begin
        if (i_en_rd) begin
            r_a <= GAMMA_ROM[w_addr_lo];
            r_b <= GAMMA_ROM[w_addr_hi];
            r_f <= i_v[F_W-1:0];
        end
    end

    // table is non-decreasing, so the difference never wraps
    assign w_d    = r_b - r_a;
    assign w_prod = P_W'(w_d) * P_W'(r_f) + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            o_y <= r_a + w_prod[P_W-1:F_W];
        end
    end

endmodule

// File: design/hcsg_lane.sv
`include "hdr_color_scale_and_gamma_core_assert.svh"

module hcsg_lane #(
    parameter int INT_BITS         = hcsg_pkg::DEF_INT_BITS,
    parameter int GAMMA_TABLE_BITS = hcsg_pkg::DEF_GAMMA_TABLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hcsg_pkg::N_STAGES-1:0] i_en,
    input  logic [hcsg_pkg::N_STAGES-1:0] i_vld,
    input  logic [INT_BITS+15:0]          i_c,
    input  logic [INT_BITS+15:0]          i_max,
    input  logic                          i_scale,
    output logic [hcsg_pkg::OUT_W-1:0]    o_y
);
    import hcsg_pkg::*;

    localparam int IN_W = 16 + INT_BITS;
    localparam int N_W  = IN_W + OUT_W;
    localparam logic [IN_W-1:0] ONE_W = IN_W'(ONE_Q16);
    localparam logic [IN_W-1:0] MAX_W = IN_W'(MAX_V);

    logic [N_W-1:0]   w_n;
    logic [OUT_W-1:0] w_clamp;

    // divider stage registers, index k feeds quotient step k
    logic [IN_W-1:0]  r_rem [0:DIV_STEPS];
    logic [OUT_W-1:0] r_low [0:DIV_STEPS];
    logic [OUT_W-1:0] r_q   [0:DIV_STEPS];
    logic [IN_W-1:0]  r_dm  [0:DIV_STEPS];
    logic             r_ds  [0:DIV_STEPS];
    logic [OUT_W-1:0] r_dcl [0:DIV_STEPS];

    logic [IN_W:0]    w_t    [DIV_STEPS];
    logic [IN_W:0]    w_diff [DIV_STEPS];
    logic             w_ge   [DIV_STEPS];
    logic [OUT_W-1:0] w_v;

    // c * 65535 as a shift and subtract
    assign w_n     = {i_c, OUT_W'(0)} - N_W'(i_c);
    assign w_clamp = (i_c > MAX_W) ? MAX_W[OUT_W-1:0] : i_c[OUT_W-1:0];

    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            w_t[k]    = {r_rem[k], r_low[k][OUT_W-1]};
            w_ge[k]   = (w_t[k] >= {1'b0, r_dm[k]});
            w_diff[k] = w_t[k] - {1'b0, r_dm[k]};
        end
    end

    // restoring division, one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (i_en[ST_MUL]) begin
            r_rem[0] <= w_n[N_W-1:OUT_W];
            r_low[0] <= w_n[OUT_W-1:0];
            r_q[0]   <= '0;
            r_dm[0]  <= i_max;
            r_ds[0]  <= i_scale;
            r_dcl[0] <= w_clamp;
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (i_en[ST_DIV0+k]) begin
                r_rem[k+1] <= w_ge[k] ? w_diff[k][IN_W-1:0] : w_t[k][IN_W-1:0];
                r_low[k+1] <= {r_low[k][OUT_W-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][OUT_W-2:0], w_ge[k]};
                r_dm[k+1]  <= r_dm[k];
                r_ds[k+1]  <= r_ds[k];
                r_dcl[k+1] <= r_dcl[k];
            end
        end
    end

    assign w_v = r_ds[DIV_STEPS] ? r_q[DIV_STEPS] : r_dcl[DIV_STEPS];

    hcsg_gamma #(
        .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
    ) u_gamma (
        .i_clk    (i_clk),
        .i_en_rd  (i_en[ST_SEL]),
        .i_en_out (i_en[ST_OUT]),
        .i_v      (w_v),
        .o_y      (o_y)
    );

    `HCSG_ASSERT_NOW(a_scale_flag, i_vld[ST_MUL], r_ds[0] == (r_dm[0] > ONE_W), "scale flag disagrees with max")

    for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_rem_chk
        `HCSG_ASSERT_NOW(a_rem_below_div, i_vld[ST_MUL+k] && r_ds[k], r_rem[k] < r_dm[k], "divider remainder out of range")
    end

endmodule

// File: design/hdr_color_scale_and_gamma_core.sv
// HDR color scale and gamma encode. Takes one linear RGB pixel per transfer (three unsigned
// Q(INT_BITS).16 channels, 65536 = 1.0) and returns one 16-bit gamma-encoded pixel. When the
// largest channel is above 1.0 every channel is scaled to floor(c*65535/max), otherwise each
// channel is clamped to 65535; the result then goes through a 1/2.2 gamma curve built from a
// 2^GAMMA_TABLE_BITS+1 entry table with linear interpolation. The block takes a new pixel on
// every clock, save when input is refused as below, and each pixel goes through its 20 register
// stages: input capture, the multiply, the 16-step restoring divider in each of the three channel
// lanes, then the table read and interpolation. Empty stages close up while the output is
// stalled, so input is refused only when all 20 stages hold pixels and the output is not taken.

`include "hdr_color_scale_and_gamma_core_assert.svh"

module hdr_color_scale_and_gamma_core #(
    parameter int INT_BITS         = hcsg_pkg::DEF_INT_BITS,
    parameter int GAMMA_TABLE_BITS = hcsg_pkg::DEF_GAMMA_TABLE_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hcsg_pix_in_if.sink     i_pix,
    hcsg_pix_out_if.source  o_pix
);
    import hcsg_pkg::*;

    localparam int IN_W = 16 + INT_BITS;

    // stage valid bits and per-stage load enables
    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] n_vld;
    logic [N_STAGES-1:0] w_en;

    // front stage outputs (max and scale flag shared by all lanes) and lane outputs
    logic [IN_W-1:0]  w_chan [NUM_CH];
    logic [IN_W-1:0]  w_max;
    logic             w_scale;
    logic [OUT_W-1:0] w_y [NUM_CH];

    logic w_in_xfer;
    logic w_out_xfer;

    // a stage loads when it is empty or its contents move on this cycle
    assign w_en[N_STAGES-1] = !r_vld[N_STAGES-1] || o_pix.ready;
    for (genvar s = 0; s < N_STAGES - 1; s++) begin : g_en
        assign w_en[s] = !r_vld[s] || w_en[s+1];
    end

    always_comb begin
        n_vld = r_vld;
        if (w_en[ST_IN]) begin
            n_vld[ST_IN] = i_pix.valid;
        end
        for (int s = 1; s < N_STAGES; s++) begin
            if (w_en[s]) begin
                n_vld[s] = r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_pix.ready = w_en[ST_IN];
    assign o_pix.valid = r_vld[N_STAGES-1];

    assign w_in_xfer  = i_pix.valid && i_pix.ready;
    assign w_out_xfer = o_pix.valid && o_pix.ready;

    // input capture and max across channels
    hcsg_max #(
        .INT_BITS (INT_BITS)
    ) u_max (
        .i_clk   (i_clk),
        .i_en    (w_en[ST_IN]),
        .i_red   (i_pix.red_in),
        .i_green (i_pix.green_in),
        .i_blue  (i_pix.blue_in),
        .o_chan  (w_chan),
        .o_max   (w_max),
        .o_scale (w_scale)
    );

    // one scale and gamma lane per color channel
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        hcsg_lane #(
            .INT_BITS         (INT_BITS),
            .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (r_vld),
            .i_c     (w_chan[ch]),
            .i_max   (w_max),
            .i_scale (w_scale),
            .o_y     (w_y[ch])
        );
    end

    // lanes merge into one output pixel
    assign o_pix.red_out   = w_y[CH_RED];
    assign o_pix.green_out = w_y[CH_GREEN];
    assign o_pix.blue_out  = w_y[CH_BLUE];

    `HCSG_ASSERT_NOW(a_ready_when_drained, !o_pix.valid, i_pix.ready, "input refused with empty output stage")
    `HCSG_ASSERT_NOW(a_refuse_only_full, !i_pix.ready, &r_vld, "input refused with a free stage")
    `HCSG_ASSERT_NEXT(a_count_held, !w_in_xfer && !w_out_xfer, $countones(r_vld) == $past($countones(r_vld)), "pixel count changed without a transfer")

endmodule

// File: tb/sv/hdr_color_scale_and_gamma_core_tb.sv
`timescale 1ns / 1ps

module hdr_color_scale_and_gamma_core_tb;
    import hcsg_pkg::*;

    // block configuration, kept at the package defaults
    localparam int INT_BITS   = DEF_INT_BITS;
    localparam int GAMMA_BITS = DEF_GAMMA_TABLE_BITS;
    localparam int IN_W       = 16 + INT_BITS;
    localparam int TBL_N      = 1 << GAMMA_BITS;
    localparam int FRAC_BITS  = 16 - GAMMA_BITS;

    // run shape
    localparam int PHASE_PIXELS   = 600;
    localparam int HOLD_OFF_LEN   = 80;    // well past the 20 pipeline stages
    localparam int DRAIN_CYCLES   = 40;    // extra wait for stray outputs after the last expected pixel
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side

    typedef logic [IN_W-1:0] lin_chan_t;
    typedef logic [NUM_CH-1:0][OUT_W-1:0] enc_pixel_t;

    // predicts the encoded pixel for every accepted input and holds the
    // predictions in arrival order until the block returns them
    class gamma_pixel_checker;
        bit [OUT_W-1:0] gamma_rom [0:TBL_N];
        enc_pixel_t     pending_pixels [$];
        int             n_noted;
        int             n_checked;
        int             n_errors;
        int             n_scaled;

        function new();
            build_gamma_rom();
        endfunction

        // T[k] is the largest y with (2y-1)^11 * N^5 <= k^5 * 131070^11,
        // i.e. 65535*(k/N)^(5/11) rounded half up, worked out exactly
        function void build_gamma_rom();
            bit [319:0] coef;
            bit [319:0] rhs;
            bit [319:0] lhs;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            coef = 320'd1;
            for (int j = 0; j < 11; j++) coef = coef * 320'd131070;
            for (int k = 0; k <= TBL_N; k++) begin
                rhs = coef;
                for (int j = 0; j < 5; j++) rhs = rhs * 320'(k);
                lo = 0;
                hi = MAX_V;
                while (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    lhs = 320'd1;
                    for (int j = 0; j < 11; j++) lhs = lhs * 320'(2 * mid - 1);
                    lhs = lhs << (5 * GAMMA_BITS);
                    if (lhs <= rhs) lo = mid;
                    else hi = mid - 1;
                end
                gamma_rom[k] = OUT_W'(lo);
            end
        endfunction

        // table lookup with linear interpolation, rounded
        function bit [OUT_W-1:0] gamma_encode(bit [OUT_W-1:0] v);
            int unsigned idx;
            int unsigned frac;
            int unsigned t_lo;
            int unsigned t_hi;
            idx  = v >> FRAC_BITS;
            frac = v & ((1 << FRAC_BITS) - 1);
            t_lo = gamma_rom[idx];
            t_hi = gamma_rom[idx + 1];
            return OUT_W'(t_lo + (((t_hi - t_lo) * frac + (1 << (FRAC_BITS - 1))) >> FRAC_BITS));
        endfunction

        function void note_pixel(lin_chan_t r, lin_chan_t g, lin_chan_t b);
            bit [63:0]  chan [NUM_CH];
            bit [63:0]  peak;
            bit [15:0]  norm;
            enc_pixel_t px;
            chan[CH_RED]   = 64'(r);
            chan[CH_GREEN] = 64'(g);
            chan[CH_BLUE]  = 64'(b);
            peak = chan[CH_RED];
            if (chan[CH_GREEN] > peak) peak = chan[CH_GREEN];
            if (chan[CH_BLUE] > peak) peak = chan[CH_BLUE];
            if (peak > ONE_Q16) n_scaled++;
            for (int c = 0; c < NUM_CH; c++) begin
                if (peak > ONE_Q16) norm = 16'((chan[c] * MAX_V) / peak);
                else if (chan[c] > MAX_V) norm = 16'(MAX_V);
                else norm = chan[c][15:0];
                px[c] = gamma_encode(norm);
            end
            pending_pixels.insert(pending_pixels.size(), px);
            n_noted++;
        endfunction

        task report_mismatch(string what);
            n_errors++;
            $display("pixel error: %s", what);
        endtask

        task check_pixel(enc_pixel_t got);
            enc_pixel_t want;
            string      ch_name [NUM_CH];
            ch_name[CH_RED]   = "red";
            ch_name[CH_GREEN] = "green";
            ch_name[CH_BLUE]  = "blue";
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("output transfer with no pixel outstanding (%h)", got));
            end else begin
                want = pending_pixels.pop_front();
                for (int c = 0; c < NUM_CH; c++) begin
                    if (got[c] !== want[c])
                        report_mismatch($sformatf("pixel %0d %s_out got %h want %h",
                                                  n_checked, ch_name[c], got[c], want[c]));
                end
                n_checked++;
            end
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hcsg_pix_in_if #(.INT_BITS(INT_BITS)) pix_in ();
    hcsg_pix_out_if                       pix_out ();

    hdr_color_scale_and_gamma_core #(
        .INT_BITS         (INT_BITS),
        .GAMMA_TABLE_BITS (GAMMA_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    gamma_pixel_checker checker_h = new();

    // idle mix per phase, in percent of cycles
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    // main process asks for one long output stall, receiver process runs it
    bit          hold_off_req = 1'b0;
    int          n_hold_offs  = 0;
    int          quiet_cycles = 0;

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    // drive every input to a known value before the first edge
    initial begin
        pix_in.valid    = 1'b0;
        pix_in.red_in   = '0;
        pix_in.green_in = '0;
        pix_in.blue_in  = '0;
        pix_out.ready   = 1'b0;
    end

    // transfer monitors, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_in.valid && pix_in.ready)
                checker_h.note_pixel(pix_in.red_in, pix_in.green_in, pix_in.blue_in);
            if (pix_out.valid && pix_out.ready)
                checker_h.check_pixel({pix_out.blue_out, pix_out.green_out, pix_out.red_out});
        end
    end

    // watchdog: ends the run if neither side moves for too long
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("hdr_color_scale_and_gamma_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // output side: random back-pressure, or one long stall on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                pix_out.ready <= 1'b0;
                // ready stays low; input keeps being offered so the pipe fills
                repeat (HOLD_OFF_LEN - 1) @(negedge i_clk);
                n_hold_offs++;
                hold_off_req = 1'b0;
            end else begin
                pix_out.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // offers one pixel after a random gap and waits for its transfer
    task automatic send_pixel(input lin_chan_t r, input lin_chan_t g, input lin_chan_t b);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.red_in   <= r;
        pix_in.green_in <= g;
        pix_in.blue_in  <= b;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
    endtask

    // one channel value drawn from a given range class
    function automatic lin_chan_t rand_channel(int unsigned kind);
        case (kind)
            0: return lin_chan_t'($urandom);                                   // full range
            1: return lin_chan_t'($urandom_range(ONE_Q16));                    // up to 1.0
            2: return lin_chan_t'($urandom_range(ONE_Q16 + 8, ONE_Q16 - 8));   // around 1.0
            default: return lin_chan_t'($urandom) >> $urandom_range(IN_W - 1); // random magnitude
        endcase
    endfunction

    task automatic send_random_pixel();
        int unsigned kind;
        kind = $urandom_range(4);
        // kind 4 mixes range classes across the three channels
        if (kind == 4)
            send_pixel(rand_channel($urandom_range(3)), rand_channel($urandom_range(3)),
                       rand_channel($urandom_range(3)));
        else
            send_pixel(rand_channel(kind), rand_channel(kind), rand_channel(kind));
    endtask

    localparam lin_chan_t CH_TOP = {IN_W{1'b1}};
    localparam lin_chan_t CH_ONE = lin_chan_t'(ONE_Q16);
    localparam lin_chan_t CH_MAX = lin_chan_t'(MAX_V);

    initial begin
        // synchronous reset, released at a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 34;
        snk_idle_pct = 51;

        // directed corners
        send_pixel(0, 0, 0);                          // all zero encodes to table entry 0
        send_pixel(CH_TOP, CH_TOP, CH_TOP);           // all at field maximum
        send_pixel(CH_ONE, CH_ONE, CH_ONE);           // peak exactly 1.0, clamp only
        send_pixel(CH_MAX, CH_MAX, CH_MAX);
        send_pixel(CH_ONE, 1, 0);                     // peak exactly 1.0 with small others
        send_pixel(CH_ONE + 1, CH_ONE, 0);            // just above 1.0, scaling kicks in
        send_pixel(CH_TOP, 0, 1);
        send_pixel(0, CH_TOP, 12345);
        send_pixel(777, 3, CH_TOP);
        send_pixel(1, 2, 3);                          // deep in the first table segment
        send_pixel(63, 64, 65);                       // interpolation fraction wrap
        send_pixel(CH_MAX - 1, CH_MAX - 64, 32);
        send_pixel(CH_TOP, CH_TOP - 1, CH_TOP >> 1);
        send_pixel(CH_ONE << 1, CH_ONE, CH_ONE >> 1); // exact ratios after scaling
        send_pixel(lin_chan_t'('h555555), lin_chan_t'('haaaaaa), lin_chan_t'('h0f0f0f));
        send_pixel(lin_chan_t'('h800000), lin_chan_t'('h7fffff), lin_chan_t'('h010000));
        send_pixel(CH_ONE - 1, CH_ONE + 2, CH_ONE - 1);

        // random part in three idle mixes
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin src_idle_pct = 34; snk_idle_pct = 51; end
                1: begin src_idle_pct = 51; snk_idle_pct = 34; end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    // long output stall while input keeps coming
                    hold_off_req = 1'b1;
                end
            endcase
            repeat (PHASE_PIXELS) send_random_pixel();
        end

        @(negedge i_clk);
        pix_in.valid <= 1'b0;

        // drain: wait for every predicted pixel, then look for strays
        while (checker_h.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d pixels (%0d needing scale-down) under two idle mixes and full rate",
                 checker_h.n_noted, checker_h.n_scaled);
        $display("output held off %0d time(s) for %0d cycles, %0d pixels compared, %0d errors",
                 n_hold_offs, HOLD_OFF_LEN, checker_h.n_checked, checker_h.n_errors);
        if (checker_h.n_errors == 0) begin
            $display("hdr_color_scale_and_gamma_core: match");
        end else begin
            $display("hdr_color_scale_and_gamma_core: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/hcsg_pkg.sv
design/hcsg_pix_in_if.sv
design/hcsg_pix_out_if.sv
design/hcsg_max.sv
design/hcsg_gamma.sv
design/hcsg_lane.sv
design/hdr_color_scale_and_gamma_core.sv
tb/sv/hdr_color_scale_and_gamma_core_tb.sv
